// ===== design/bmm_pkg.sv =====
// Package for the banked memory map decoder: access kinds, port codes,
// read-source codes, reset values and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bmm_pkg;

  localparam logic [2:0] KIND_MEM_RD    = 3'd0;
  localparam logic [2:0] KIND_MEM_WR    = 3'd1;
  localparam logic [2:0] KIND_IO_RD     = 3'd2;
  localparam logic [2:0] KIND_IO_WR     = 3'd3;
  localparam logic [2:0] KIND_HBLANK_ON = 3'd4;
  localparam logic [2:0] KIND_HBLANK_OFF = 3'd5;
  localparam logic [2:0] KIND_TEMPO     = 3'd6;

  localparam logic [7:0] PORT_PTR0     = 8'h00;
  localparam logic [7:0] PORT_PTR1     = 8'h01;
  localparam logic [7:0] PORT_PTR2     = 8'h02;
  localparam logic [7:0] PORT_EXP_DATA = 8'h03;
  localparam logic [7:0] PORT_CLR_INH0 = 8'hE0;
  localparam logic [7:0] PORT_CLR_INH1 = 8'hE1;
  localparam logic [7:0] PORT_SET_INH0 = 8'hE2;
  localparam logic [7:0] PORT_SET_INH1 = 8'hE3;
  localparam logic [7:0] PORT_SET_BOTH = 8'hE4;
  localparam logic [7:0] PORT_SAVE_INH = 8'hE5;
  localparam logic [7:0] PORT_LOAD_INH = 8'hE6;

  localparam logic [1:0] RD_CONST = 2'd0;
  localparam logic [1:0] RD_MAIN  = 2'd1;
  localparam logic [1:0] RD_VIDEO = 2'd2;
  localparam logic [1:0] RD_EXP   = 2'd3;

  localparam logic [1:0] DEV_NONE  = 2'd0;
  localparam logic [1:0] DEV_PPI   = 2'd1;
  localparam logic [1:0] DEV_TIMER = 2'd2;
  localparam logic [1:0] DEV_GATE  = 2'd3;

  localparam logic [1:0] BR_NONE    = 2'd0;
  localparam logic [1:0] BR_ASSERT  = 2'd1;
  localparam logic [1:0] BR_RELEASE = 2'd2;

  localparam logic [1:0] INHIBIT_RESET  = 2'd3;
  localparam logic [7:0] VRAM_HI_RESET  = 8'h71;
  localparam logic [7:0] BOOT_ROM_BYTE  = 8'hFF;
  localparam logic [7:0] OPEN_BUS_BYTE  = 8'hFF;
  localparam logic [7:0] STATUS_BASE    = 8'h7E;

  typedef struct packed {
    logic main_we;
    logic main_re;
    logic vid_we;
    logic vid_re;
    logic exp_we;
    logic exp_re;
  } mem_ctl_t;

  typedef struct packed {
    logic [1:0] rd_src;
    logic [7:0] rd_const;
    logic       wait_states;
    logic [1:0] bus_request;
    logic [1:0] device_select;
    logic [1:0] device_register;
    logic       device_is_write;
    logic [7:0] device_write_data;
  } res_t;

endpackage
`default_nettype wire

// ===== design/bmm_decode.sv =====
// Address/port decode for one beat: memory strobes, result fields and next state.
// Depends on bmm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bmm_decode #(
  parameter int EXPANSION_ADDR_BITS = 19
) (
  input  wire logic [2:0]                     kind,
  input  wire logic [15:0]                    addr,
  input  wire logic [7:0]                     data,
  input  wire logic [1:0]                     inhibit,
  input  wire logic [1:0]                     backup,
  input  wire logic                           hblank,
  input  wire logic                           tempo,
  input  wire logic [EXPANSION_ADDR_BITS-1:0] ptr,
  output bmm_pkg::mem_ctl_t                   mc,
  output bmm_pkg::res_t                       res,
  output logic [1:0]                          inhibit_nxt,
  output logic [1:0]                          backup_nxt,
  output logic                                hblank_nxt,
  output logic                                tempo_nxt,
  output logic [EXPANSION_ADDR_BITS-1:0]      ptr_nxt
);

  always_comb begin
    logic        mem;
    logic        wr;
    logic        boot;
    logic        vid;
    logic        dev;
    logic [23:0] p24;
    logic [7:0]  port;
    mem  = (kind == bmm_pkg::KIND_MEM_RD) || (kind == bmm_pkg::KIND_MEM_WR);
    wr   = (kind == bmm_pkg::KIND_MEM_WR);
    boot = inhibit[0] && (addr[15:12] == 4'h0);
    vid  = inhibit[1] && (addr[15:12] == 4'hD);
    dev  = inhibit[1] && (addr[15:13] == 3'b111);
    p24  = 24'(ptr);
    port = addr[7:0];

    mc          = '0;
    res         = '0;
    res.rd_src  = bmm_pkg::RD_CONST;
    inhibit_nxt = inhibit;
    backup_nxt  = backup;
    hblank_nxt  = hblank;
    tempo_nxt   = tempo;
    ptr_nxt     = ptr;

    case (kind)
      bmm_pkg::KIND_MEM_RD, bmm_pkg::KIND_MEM_WR: begin
        res.wait_states = mem && boot;
        if (vid) begin
          res.bus_request = hblank ? bmm_pkg::BR_ASSERT : bmm_pkg::BR_NONE;
          mc.vid_we = wr;
          mc.vid_re = !wr;
          if (!wr) res.rd_src = bmm_pkg::RD_VIDEO;
        end else if (dev) begin
          if (!addr[3]) begin
            res.device_select   = addr[2] ? bmm_pkg::DEV_TIMER : bmm_pkg::DEV_PPI;
            res.device_register = addr[1:0];
            res.device_is_write = wr;
            res.device_write_data = wr ? data : 8'h00;
          end else if (addr[2:0] == 3'd0) begin
            if (wr) begin
              res.device_select     = bmm_pkg::DEV_GATE;
              res.device_is_write   = 1'b1;
              res.device_write_data = data;
            end else begin
              res.rd_const = bmm_pkg::STATUS_BASE | {hblank, 6'd0, tempo};
            end
          end else if (!wr) begin
            res.rd_const = bmm_pkg::OPEN_BUS_BYTE;
          end
        end else if (boot) begin
          if (!wr) res.rd_const = bmm_pkg::BOOT_ROM_BYTE;
        end else begin
          mc.main_we = wr;
          mc.main_re = !wr;
          if (!wr) res.rd_src = bmm_pkg::RD_MAIN;
        end
      end
      bmm_pkg::KIND_IO_RD: begin
        case (port)
          bmm_pkg::PORT_PTR0: res.rd_const = p24[7:0];
          bmm_pkg::PORT_PTR1: res.rd_const = p24[15:8];
          bmm_pkg::PORT_PTR2: res.rd_const = p24[23:16];
          bmm_pkg::PORT_EXP_DATA: begin
            mc.exp_re  = 1'b1;
            res.rd_src = bmm_pkg::RD_EXP;
            ptr_nxt    = ptr + 1'b1;
          end
          default: res.rd_const = bmm_pkg::OPEN_BUS_BYTE;
        endcase
      end
      bmm_pkg::KIND_IO_WR: begin
        case (port)
          bmm_pkg::PORT_PTR0: ptr_nxt = EXPANSION_ADDR_BITS'({p24[23:8], data});
          bmm_pkg::PORT_PTR1: ptr_nxt = EXPANSION_ADDR_BITS'({p24[23:16], data, p24[7:0]});
          bmm_pkg::PORT_PTR2: ptr_nxt = EXPANSION_ADDR_BITS'({data, p24[15:0]});
          bmm_pkg::PORT_EXP_DATA: begin
            mc.exp_we = 1'b1;
            ptr_nxt   = ptr + 1'b1;
          end
          bmm_pkg::PORT_CLR_INH0: inhibit_nxt = inhibit & 2'b10;
          bmm_pkg::PORT_CLR_INH1: inhibit_nxt = inhibit & 2'b01;
          bmm_pkg::PORT_SET_INH0: inhibit_nxt = inhibit | 2'b01;
          bmm_pkg::PORT_SET_INH1: inhibit_nxt = inhibit | 2'b10;
          bmm_pkg::PORT_SET_BOTH: inhibit_nxt = 2'b11;
          bmm_pkg::PORT_SAVE_INH: backup_nxt  = inhibit;
          bmm_pkg::PORT_LOAD_INH: inhibit_nxt = backup;
          default: ;
        endcase
      end
      bmm_pkg::KIND_HBLANK_ON: hblank_nxt = 1'b1;
      bmm_pkg::KIND_HBLANK_OFF: begin
        hblank_nxt      = 1'b0;
        res.bus_request = bmm_pkg::BR_RELEASE;
      end
      bmm_pkg::KIND_TEMPO: tempo_nxt = !tempo;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/bmm_mem.sv =====
// Main RAM, video RAM and expansion RAM with registered reads and a
// clearing pass after reset. Depends on bmm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bmm_mem #(
  parameter int EXPANSION_ADDR_BITS = 19
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire bmm_pkg::mem_ctl_t              mc,
  input  wire logic [15:0]                    addr,
  input  wire logic [7:0]                     wdata,
  input  wire logic [EXPANSION_ADDR_BITS-1:0] exp_addr,
  output logic                                clear_busy,
  output logic [7:0]                          main_q,
  output logic [7:0]                          vid_q,
  output logic [7:0]                          exp_q
);

  localparam int CW = (EXPANSION_ADDR_BITS > 16) ? EXPANSION_ADDR_BITS : 16;
  localparam int EXP_DEPTH = 1 << EXPANSION_ADDR_BITS;

  logic [7:0] main_ram [65536];
  logic [7:0] video_ram [4096];
  logic [7:0] exp_ram [EXP_DEPTH];

  logic [CW-1:0] clr_r;
  logic          busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == '1) busy_r <= 1'b0;
    end
  end

  // Wrapped clear addresses just rewrite the reset value.
  always_ff @(posedge clk) begin
    if (busy_r) begin
      main_ram[clr_r[15:0]] <= 8'h00;
    end else if (mc.main_we) begin
      main_ram[addr] <= wdata;
    end
    if (mc.main_re) main_q <= main_ram[addr];
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      video_ram[clr_r[11:0]] <= clr_r[11] ? bmm_pkg::VRAM_HI_RESET : 8'h00;
    end else if (mc.vid_we) begin
      video_ram[addr[11:0]] <= wdata;
    end
    if (mc.vid_re) vid_q <= video_ram[addr[11:0]];
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      exp_ram[clr_r[EXPANSION_ADDR_BITS-1:0]] <= 8'h00;
    end else if (mc.exp_we) begin
      exp_ram[exp_addr] <= wdata;
    end
    if (mc.exp_re) exp_q <= exp_ram[exp_addr];
  end

  assign clear_busy = busy_r;

endmodule
`default_nettype wire

// ===== design/banked_memory_map_decoder.sv =====
// Banked memory map decoder: input register, decode plus memory access, result register.
// Each beat passes the input register, then the result register; one beat per cycle sustained while out_tready is high.
// After reset the clear counter, max(16, EXPANSION_ADDR_BITS) bits wide, steps through every
// value to clear the memories, during which in_tready stays low.
// Reset restores inhibit bits 3, backup 3, hblank 0, tempo 0, pointer 0.
// Depends on bmm_pkg, bmm_decode, bmm_mem.
`timescale 1ns / 1ps
`default_nettype none
module banked_memory_map_decoder #(
  parameter int EXPANSION_ADDR_BITS = 19
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // addr[15:0], data[23:16]
  input  wire logic [2:0]  in_tuser,   // kind[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // read_data[7:0], wait_states[8], bus_request[10:9], device_select[12:11],
  // device_register[14:13], device_is_write[15], device_write_data[23:16]
  output logic [23:0]      out_tdata
);

  logic        a_valid_r;
  logic [2:0]  a_kind_r;
  logic [15:0] a_addr_r;
  logic [7:0]  a_data_r;
  logic        b_valid_r;
  bmm_pkg::res_t res_r;

  logic [1:0] inhibit_r, backup_r;
  logic       hblank_r, tempo_r;
  logic [EXPANSION_ADDR_BITS-1:0] ptr_r;

  bmm_pkg::mem_ctl_t mc, mc_gated;
  bmm_pkg::res_t     res;
  logic [1:0] inhibit_nxt, backup_nxt;
  logic       hblank_nxt, tempo_nxt;
  logic [EXPANSION_ADDR_BITS-1:0] ptr_nxt;
  logic       clear_busy;
  logic [7:0] main_q, vid_q, exp_q;
  logic [7:0] read_data;
  logic       en, step;

  assign en        = !b_valid_r || out_tready;
  assign step      = a_valid_r && en;
  assign in_tready = !clear_busy && (!a_valid_r || en);
  assign mc_gated  = step ? mc : '0;

  bmm_decode #(
    .EXPANSION_ADDR_BITS(EXPANSION_ADDR_BITS)
  ) u_decode (
    .kind       (a_kind_r),
    .addr       (a_addr_r),
    .data       (a_data_r),
    .inhibit    (inhibit_r),
    .backup     (backup_r),
    .hblank     (hblank_r),
    .tempo      (tempo_r),
    .ptr        (ptr_r),
    .mc         (mc),
    .res        (res),
    .inhibit_nxt(inhibit_nxt),
    .backup_nxt (backup_nxt),
    .hblank_nxt (hblank_nxt),
    .tempo_nxt  (tempo_nxt),
    .ptr_nxt    (ptr_nxt)
  );

  bmm_mem #(
    .EXPANSION_ADDR_BITS(EXPANSION_ADDR_BITS)
  ) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .mc        (mc_gated),
    .addr      (a_addr_r),
    .wdata     (a_data_r),
    .exp_addr  (ptr_r),
    .clear_busy(clear_busy),
    .main_q    (main_q),
    .vid_q     (vid_q),
    .exp_q     (exp_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      inhibit_r <= bmm_pkg::INHIBIT_RESET;
      backup_r  <= bmm_pkg::INHIBIT_RESET;
      hblank_r  <= 1'b0;
      tempo_r   <= 1'b0;
      ptr_r     <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        a_valid_r <= 1'b1;
      end else if (step) begin
        a_valid_r <= 1'b0;
      end
      if (en) b_valid_r <= a_valid_r;
      if (step) begin
        inhibit_r <= inhibit_nxt;
        backup_r  <= backup_nxt;
        hblank_r  <= hblank_nxt;
        tempo_r   <= tempo_nxt;
        ptr_r     <= ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_kind_r <= in_tuser;
      a_addr_r <= in_tdata[15:0];
      a_data_r <= in_tdata[23:16];
    end
    if (step) res_r <= res;
  end

  always_comb begin
    case (res_r.rd_src)
      bmm_pkg::RD_MAIN:  read_data = main_q;
      bmm_pkg::RD_VIDEO: read_data = vid_q;
      bmm_pkg::RD_EXP:   read_data = exp_q;
      default:           read_data = res_r.rd_const;
    endcase
  end

  assign out_tvalid = b_valid_r;
  assign out_tdata  = {res_r.device_write_data, res_r.device_is_write,
                       res_r.device_register, res_r.device_select,
                       res_r.bus_request, res_r.wait_states, read_data};

endmodule
`default_nettype wire
